@@ hw/rtl/tpc_pkg.sv @@
// Shared types, constants and ones' complement helper for the TCP checksum unit.
`timescale 1ns / 1ps

package tpc_pkg;

   localparam int QueueDepth = 4;

   // byte positions within the IPv4 header
   localparam logic [15:0] IdxVersion  = 16'd0;
   localparam logic [15:0] IdxTotLenHi = 16'd2;
   localparam logic [15:0] IdxTotLenLo = 16'd3;
   localparam logic [15:0] IdxProto    = 16'd9;
   localparam logic [15:0] IdxSrcAddr  = 16'd12;
   localparam logic [15:0] IdxSegment  = 16'd20;
   localparam logic [15:0] IdxMax      = 16'hFFFF;

   localparam logic [5:0] IpMinHeader = 6'd20;
   localparam logic [7:0] ProtoTcp    = 8'd6;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NOT_TCP      = 2'd1,
      STATUS_LEN_MISMATCH = 2'd2,
      STATUS_TRUNCATED    = 2'd3
   } status_type;

   // one unit of work handed from the classifier to the accumulator
   typedef struct packed {
      logic [15:0] word;
      logic        fin;
      status_type  status;
      logic [15:0] len;
   } queue_entry_type;

   function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

endpackage

@@ hw/rtl/tpc_queue.sv @@
// Short request queue between the classifier and the accumulator.
`timescale 1ns / 1ps

module tpc_queue #(
   parameter int DEPTH = tpc_pkg::QueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tpc_pkg::queue_entry_type push_entry,
   output logic                     full,
   output logic                     valid,
   output tpc_pkg::queue_entry_type head_entry,
   input  logic                     pop
);
   import tpc_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   queue_entry_type store_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntW'(DEPTH));
   assign valid      = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/tpc_front.sv @@
// Byte classifier: tracks header fields, forms 16-bit words and final status.
`timescale 1ns / 1ps

module tpc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     last,
   output logic                     q_push,
   output tpc_pkg::queue_entry_type q_entry
);
   import tpc_pkg::*;

   logic [15:0] byte_cnt_ff, byte_cnt_in;
   logic        ovf_ff, ovf_in;
   logic [5:0]  hdr_ff, hdr_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  held_ff, held_in;
   logic        err_ff, err_in;

   logic [15:0] idx;
   logic        in_zone;
   logic [5:0]  hl_raw;
   logic        word_ok;
   logic [16:0] count;
   logic        trunc;

   assign idx     = byte_cnt_ff;
   assign in_zone = (idx >= IdxSrcAddr && idx < IdxSegment)
                 || (idx >= IdxSegment && idx >= {10'd0, hdr_ff});
   assign hl_raw  = {data_byte[3:0], 2'b00};

   always_comb begin
      byte_cnt_in = byte_cnt_ff;
      ovf_in      = ovf_ff;
      hdr_in      = hdr_ff;
      total_in    = total_ff;
      held_in     = held_ff;
      err_in      = err_ff;
      word_ok     = 1'b0;
      q_entry     = '0;
      count       = {1'b0, idx} + 17'd1;
      trunc       = 1'b0;

      if (accept && !ovf_ff) begin
         if (idx == IdxVersion) begin
            hdr_in = (hl_raw < IpMinHeader) ? IpMinHeader : hl_raw;
         end else if (idx == IdxTotLenHi) begin
            total_in = {data_byte, 8'h00};
         end else if (idx == IdxTotLenLo) begin
            total_in = {total_ff[15:8], data_byte};
         end else if (idx == IdxProto) begin
            word_ok      = 1'b1;
            q_entry.word = {8'h00, data_byte};
            if (data_byte != ProtoTcp) begin
               err_in = 1'b1;
            end
         end
         if (in_zone) begin
            if (!idx[0]) begin
               held_in = data_byte;
               // odd-length segment: pad the last byte with a zero low byte
               if (last && idx >= {10'd0, hdr_ff}) begin
                  word_ok      = 1'b1;
                  q_entry.word = {data_byte, 8'h00};
               end
            end else begin
               word_ok      = 1'b1;
               q_entry.word = {held_ff, data_byte};
            end
         end
      end

      trunc          = !ovf_ff && (count < {11'd0, hdr_in});
      q_entry.fin    = last;
      q_entry.len    = total_in - {10'd0, hdr_in};
      if (trunc) begin
         q_entry.status = STATUS_TRUNCATED;
      end else if (err_in) begin
         q_entry.status = STATUS_NOT_TCP;
      end else if (ovf_ff || count != {1'b0, total_in}) begin
         q_entry.status = STATUS_LEN_MISMATCH;
      end else begin
         q_entry.status = STATUS_OK;
      end

      q_push = accept && (word_ok || last);

      if (accept) begin
         if (last) begin
            byte_cnt_in = '0;
            ovf_in      = 1'b0;
            hdr_in      = '0;
            total_in    = '0;
            held_in     = '0;
            err_in      = 1'b0;
         end else if (idx == IdxMax) begin
            ovf_in = 1'b1;
         end else begin
            byte_cnt_in = idx + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         hdr_ff      <= '0;
         total_ff    <= '0;
         held_ff     <= '0;
         err_ff      <= 1'b0;
      end else begin
         byte_cnt_ff <= byte_cnt_in;
         ovf_ff      <= ovf_in;
         hdr_ff      <= hdr_in;
         total_ff    <= total_in;
         held_ff     <= held_in;
         err_ff      <= err_in;
      end
   end

endmodule

@@ hw/rtl/tpc_back.sv @@
// Accumulator: ones' complement sum of queued words and the result register.
`timescale 1ns / 1ps

module tpc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  tpc_pkg::queue_entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [15:0]              rsp_checksum_sum,
   output tpc_pkg::status_type      rsp_status
);
   import tpc_pkg::*;

   logic [15:0] sum_ff, sum_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_sum_ff, out_sum_in;
   status_type  out_status_ff, out_status_in;
   logic [15:0] sum_word;
   logic        load;

   assign sum_word = add_ones(sum_ff, q_entry.word);
   // a final request needs the result register free, or freed this cycle
   assign q_pop    = q_valid && (!q_entry.fin || !out_valid_ff || rsp_pop);
   assign load     = q_pop && q_entry.fin;

   always_comb begin
      sum_in        = sum_ff;
      out_valid_in  = out_valid_ff;
      out_sum_in    = out_sum_ff;
      out_status_in = out_status_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         if (q_entry.fin) begin
            sum_in        = '0;
            out_valid_in  = 1'b1;
            out_status_in = q_entry.status;
            out_sum_in    = (q_entry.status == STATUS_TRUNCATED)
                          ? 16'd0 : add_ones(sum_word, q_entry.len);
         end else begin
            sum_in = sum_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_sum_ff    <= out_sum_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_checksum_sum = out_sum_ff;
   assign rsp_status       = out_status_ff;

endmodule

@@ hw/rtl/tcp_pseudo_header_checksum_unit.sv @@
// Top level of the TCP pseudo-header checksum unit.
// A final byte's result is written into the queue, then loaded into the result register that drives the result ports.
// Throughput: one byte per cycle while req_full is low.
// The queue between classifier and accumulator absorbs result-side stalls.
// Reset (synchronous, active high) clears all counters, sums and queues.
`timescale 1ns / 1ps

module tcp_pseudo_header_checksum_unit #(
   parameter int QUEUE_DEPTH = tpc_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [15:0]         rsp_checksum_sum,
   output tpc_pkg::status_type rsp_status
);
   import tpc_pkg::*;

   logic            accept;
   logic            q_push;
   logic            q_full;
   logic            q_valid;
   logic            q_pop;
   queue_entry_type push_entry;
   queue_entry_type head_entry;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   tpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last      (req_last),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   tpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .valid      (q_valid),
      .head_entry (head_entry),
      .pop        (q_pop)
   );

   tpc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (head_entry),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_checksum_sum (rsp_checksum_sum),
      .rsp_status       (rsp_status)
   );

   a_final_queued: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |-> q_push)
      else $error("final request not queued");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue written while full");

   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status == STATUS_TRUNCATED |-> rsp_checksum_sum == 16'd0)
      else $error("truncated packet with non-zero sum");

   a_result_from_queue: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(q_pop && head_entry.fin))
      else $error("result appeared without a final request");

endmodule

@@ tb/tcp_checksum_checker.sv @@
// Checker for the TCP checksum unit: predicts each packet's sum and status and compares.
`timescale 1ns / 1ps

module tcp_checksum_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic                req_full,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   input  logic                rsp_empty,
   input  logic                rsp_pop,
   input  logic [15:0]         rsp_checksum_sum,
   input  tpc_pkg::status_type rsp_status,
   output int                  fail_count,
   output int                  outstanding,
   output int                  results_checked
);
   import tpc_pkg::*;

   typedef struct {
      logic [15:0] sum;
      status_type  status;
   } packet_verdict_type;

   packet_verdict_type expected_sums[$];

   // running copy of the unit's per-packet state
   logic [15:0] pos;
   logic [15:0] run_sum;
   logic [5:0]  hdr_len;
   logic [15:0] tot_len;
   logic [7:0]  held_hi;
   logic        not_tcp;
   logic        overlong;

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

   function automatic void clear_tally();
      pos      = '0;
      run_sum  = '0;
      hdr_len  = '0;
      tot_len  = '0;
      held_hi  = '0;
      not_tcp  = 1'b0;
      overlong = 1'b0;
   endfunction

   // folds one request into the sum; returns 1 with the verdict on the final byte
   function automatic bit absorb_byte(input logic [7:0] b, input logic fin,
                                      output packet_verdict_type verdict);
      logic [5:0]  hl;
      logic [16:0] count;
      bit          in_span;
      verdict.sum    = '0;
      verdict.status = STATUS_OK;
      if (!overlong) begin
         if (pos == IdxVersion) begin
            hl = {b[3:0], 2'b00};
            if (hl < IpMinHeader) hl = IpMinHeader;
            hdr_len = hl;
         end else if (pos == IdxTotLenHi) begin
            tot_len = {b, 8'h00};
         end else if (pos == IdxTotLenLo) begin
            tot_len[7:0] = b;
         end else if (pos == IdxProto) begin
            run_sum = fold_add(run_sum, {8'h00, b});
            if (b != ProtoTcp) not_tcp = 1'b1;
         end
         in_span = (pos >= IdxSrcAddr && pos < IdxSegment) ||
                   (pos >= IdxSegment && pos >= {10'd0, hdr_len});
         if (in_span) begin
            if (!pos[0]) begin
               held_hi = b;
               // odd trailing byte gets a zero low half
               if (fin && pos >= {10'd0, hdr_len}) run_sum = fold_add(run_sum, {b, 8'h00});
            end else begin
               run_sum = fold_add(run_sum, {held_hi, b});
            end
         end
      end
      if (fin) begin
         count = {1'b0, pos} + 17'd1;
         if (!overlong && count < {11'd0, hdr_len}) begin
            verdict.status = STATUS_TRUNCATED;
         end else begin
            if (not_tcp) verdict.status = STATUS_NOT_TCP;
            else if (overlong || count != {1'b0, tot_len}) verdict.status = STATUS_LEN_MISMATCH;
            verdict.sum = fold_add(run_sum, tot_len - {10'd0, hdr_len});
         end
         clear_tally();
         return 1'b1;
      end
      if (pos == IdxMax) overlong = 1'b1;
      else pos = pos + 16'd1;
      return 1'b0;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count = fail_count + 1;
   endtask

   initial begin
      fail_count      = 0;
      results_checked = 0;
      outstanding     = 0;
      clear_tally();
   end

   always @(posedge clock) begin
      packet_verdict_type exp_v;
      packet_verdict_type new_v;
      if (reset) begin
         clear_tally();
         expected_sums.delete();
      end else begin
         // compare before predicting, so an early result cannot match itself
         if (rsp_pop && !rsp_empty) begin
            results_checked = results_checked + 1;
            if (expected_sums.size() == 0) begin
               flag_mismatch("result popped with no packet outstanding");
            end else begin
               exp_v = expected_sums.pop_front();
               if (rsp_checksum_sum !== exp_v.sum)
                  flag_mismatch($sformatf("checksum_sum %h, expected %h",
                                          rsp_checksum_sum, exp_v.sum));
               if (rsp_status !== exp_v.status)
                  flag_mismatch($sformatf("status %s, expected %s",
                                          rsp_status.name(), exp_v.status.name()));
            end
         end
         if (req_push && !req_full) begin
            if (absorb_byte(req_data_byte, req_last, new_v)) expected_sums.push_back(new_v);
         end
      end
      outstanding = expected_sums.size();
   end

endmodule

@@ tb/tb_tcp_pseudo_header_checksum_unit.sv @@
// Testbench top for the TCP checksum unit: clock, reset, packet stimulus and verdict.
`timescale 1ns / 1ps

module tb_tcp_pseudo_header_checksum_unit;
   import tpc_pkg::*;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   localparam int CycleLimit  = 400000;
   localparam int HoldCycles  = 300;
   localparam int IdlePercent = 37;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [15:0] rsp_checksum_sum;
   status_type  rsp_status;

   int fail_count;
   int outstanding;
   int results_checked;

   int  cycle_count = 0;
   int  bytes_sent = 0;
   int  packets_sent = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;
   bit  hold_req = 1'b0;

   logic [7:0] pkt[$];
   int         pkt_hdr_len;

   tcp_pseudo_header_checksum_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_checksum_sum (rsp_checksum_sum),
      .rsp_status       (rsp_status)
   );

   tcp_checksum_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_checksum_sum (rsp_checksum_sum),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .results_checked  (results_checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: random pops, one long hold-off on request
   initial begin
      bit held;
      held = 1'b0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end else begin
            rsp_pop <= rx_idle_on ? ($urandom_range(0, 99) >= IdlePercent) : 1'b1;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (tx_idle_on && $urandom_range(0, 99) < IdlePercent) begin
         req_push      <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_last      <= 1'($urandom);
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last      <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent = bytes_sent + 1;
      @(negedge clock);
   endtask

   task automatic build_packet(input logic [3:0] ihl, input logic [7:0] proto,
                               input int seg_len, input int len_delta,
                               input fill_kind_type fill);
      logic [15:0] field;
      pkt_hdr_len = (ihl < 4'd5) ? 20 : int'(ihl) * 4;
      field = 16'(pkt_hdr_len + seg_len + len_delta);
      pkt.delete();
      for (int i = 0; i < pkt_hdr_len + seg_len; i++) begin
         case (fill)
            FILL_ZERO: pkt.push_back(8'h00);
            FILL_ONES: pkt.push_back(8'hFF);
            default:   pkt.push_back(8'($urandom));
         endcase
      end
      pkt[0] = {4'h4, ihl};
      pkt[2] = field[15:8];
      pkt[3] = field[7:0];
      pkt[9] = proto;
   endtask

   // sends the first cut bytes of the packet, or all of it when cut is 0
   task automatic send_packet(input int cut);
      int n;
      n = (cut <= 0 || cut > pkt.size()) ? pkt.size() : cut;
      for (int i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
      packets_sent = packets_sent + 1;
   endtask

   initial begin
      int          pick;
      int          base_bytes;
      logic [3:0]  ihl_pick;
      logic [7:0]  proto_pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: header corners, each status and its priority
      build_packet(4'd5, ProtoTcp, 0, 0, FILL_RANDOM);   send_packet(0);
      build_packet(4'd5, ProtoTcp, 1, 0, FILL_RANDOM);   send_packet(0);
      build_packet(4'd15, ProtoTcp, 3, 0, FILL_RANDOM);  send_packet(0);
      build_packet(4'd2, ProtoTcp, 4, 0, FILL_RANDOM);   send_packet(0);
      build_packet(4'd0, ProtoTcp, 2, 0, FILL_RANDOM);   send_packet(0);
      build_packet(4'd5, 8'd17, 4, 0, FILL_RANDOM);      send_packet(0);
      build_packet(4'd5, ProtoTcp, 5, 3, FILL_RANDOM);   send_packet(0);
      build_packet(4'd5, 8'd1, 5, -7, FILL_RANDOM);      send_packet(0);
      build_packet(4'd5, ProtoTcp, 6, 0, FILL_RANDOM);   send_packet(9);
      build_packet(4'd5, 8'd17, 6, 0, FILL_RANDOM);      send_packet(15);
      build_packet(4'd6, ProtoTcp, 4, 0, FILL_RANDOM);   send_packet(23);
      build_packet(4'd5, ProtoTcp, 4, 0, FILL_RANDOM);   send_packet(20);
      build_packet(4'd5, ProtoTcp, 0, 0, FILL_RANDOM);   send_packet(1);
      // TCP length wraps below zero
      build_packet(4'd5, ProtoTcp, 0, -12, FILL_RANDOM); send_packet(0);
      build_packet(4'd5, ProtoTcp, 7, 0, FILL_ONES);     send_packet(0);
      build_packet(4'd5, ProtoTcp, 7, 0, FILL_ZERO);     send_packet(0);
      build_packet(4'd15, 8'hFF, 9, 0, FILL_ONES);       send_packet(0);

      // result side stalls while one-byte packets keep coming
      hold_req = 1'b1;
      repeat (30) begin
         pkt.delete();
         pkt.push_back(8'($urandom));
         send_packet(0);
      end

      base_bytes = bytes_sent;
      while (bytes_sent - base_bytes < 400) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            ihl_pick = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            build_packet(ihl_pick, ProtoTcp, $urandom_range(0, 40), 0, FILL_RANDOM);
            send_packet(0);
         end else if (pick < 76) begin
            build_packet(4'd5, 8'($urandom), $urandom_range(0, 30), 0, FILL_RANDOM);
            send_packet(0);
         end else if (pick < 82) begin
            build_packet(4'd5, ProtoTcp, $urandom_range(0, 30),
                          int'($urandom_range(0, 80)) - 40, FILL_RANDOM);
            send_packet(0);
         end else if (pick < 88) begin
            build_packet(4'($urandom_range(5, 15)), ProtoTcp, $urandom_range(0, 10), 0,
                         FILL_RANDOM);
            send_packet($urandom_range(1, pkt_hdr_len - 1));
         end else if (pick < 94) begin
            proto_pick = $urandom_range(0, 1) ? ProtoTcp : 8'($urandom);
            build_packet(4'($urandom), proto_pick, $urandom_range(0, 20),
                         int'($urandom_range(0, 4)) - 2, FILL_RANDOM);
            pkt[0][7:4] = 4'($urandom);
            send_packet(0);
         end else begin
            pkt.delete();
            repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
            send_packet(0);
         end
      end

      // long stretch at full rate on both sides
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (4) begin
         build_packet(4'd5, ProtoTcp, $urandom_range(20, 40), 0, FILL_RANDOM);
         send_packet(0);
      end

      req_push <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("covered %0d packets, %0d bytes, %0d results checked", packets_sent,
               bytes_sent, results_checked);
      $display("incl. header corners, all statuses, a stalled result side, a full-rate stretch");
      if (fail_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
